// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== sv/mexp_pkg.sv =====
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Widths, register map, microcode control word and the microcode program.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mexp_pkg;

    localparam int unsigned OPND_W      = 31;
    localparam int unsigned MOD_W       = 30;
    localparam int unsigned PROD_W      = 2 * OPND_W;
    localparam int unsigned CNT_W       = $clog2(PROD_W + 1);
    localparam int unsigned IN_TDATA_W  = 64;
    localparam int unsigned OUT_TDATA_W = 32;
    localparam int unsigned APB_AW      = 2;
    localparam int unsigned APB_DW      = 32;
    localparam int unsigned PC_W        = 4;

    localparam logic [MOD_W-1:0]  MODULUS_RESET = 30'd1000000007;
    localparam logic [APB_AW-1:0] ADDR_MODULUS  = 2'd0;

    typedef logic [PC_W-1:0] t_pc;

    typedef enum logic [3:0] {
        ACT_NOP        = 4'd0,
        ACT_LOAD       = 4'd1,
        ACT_MUL_SQ_ONE = 4'd2,
        ACT_MUL_ACC_SQ = 4'd3,
        ACT_MUL_SQ_SQ  = 4'd4,
        ACT_REDUCE     = 4'd5,
        ACT_WB_SQ      = 4'd6,
        ACT_WB_ACC     = 4'd7,
        ACT_SHIFT      = 4'd8,
        ACT_CLR_ACC    = 4'd9,
        ACT_OUT        = 4'd10
    } t_act;

    typedef enum logic [3:0] {
        COND_NEVER     = 4'd0,
        COND_ALWAYS    = 4'd1,
        COND_NO_INPUT  = 4'd2,
        COND_TRIVIAL   = 4'd3,
        COND_RED_MORE  = 4'd4,
        COND_EXP_ZERO  = 4'd5,
        COND_BIT_CLEAR = 4'd6,
        COND_LAST_BIT  = 4'd7,
        COND_OUT_BUSY  = 4'd8
    } t_cond;

    typedef struct packed {
        t_act  act;
        t_cond cond;
        t_pc   target;
    } t_ctrl;

    localparam t_pc PC_IDLE   = 4'd0;
    localparam t_pc PC_TEST   = 4'd1;
    localparam t_pc PC_PRE    = 4'd2;
    localparam t_pc PC_PRE_R  = 4'd3;
    localparam t_pc PC_PRE_W  = 4'd4;
    localparam t_pc PC_EZERO  = 4'd5;
    localparam t_pc PC_BIT    = 4'd6;
    localparam t_pc PC_MUL    = 4'd7;
    localparam t_pc PC_MUL_R  = 4'd8;
    localparam t_pc PC_MUL_W  = 4'd9;
    localparam t_pc PC_SHIFT  = 4'd10;
    localparam t_pc PC_SQR    = 4'd11;
    localparam t_pc PC_SQR_R  = 4'd12;
    localparam t_pc PC_SQR_W  = 4'd13;
    localparam t_pc PC_ZERO   = 4'd14;
    localparam t_pc PC_FINISH = 4'd15;

    // A step jumps to its target when its condition holds, else it falls through.
    function automatic t_ctrl ucode_rom(input t_pc pc);
        t_ctrl w;
        begin
            case (pc)
                PC_IDLE:   w = '{ACT_LOAD,       COND_NO_INPUT,  PC_IDLE};
                PC_TEST:   w = '{ACT_NOP,        COND_TRIVIAL,   PC_ZERO};
                PC_PRE:    w = '{ACT_MUL_SQ_ONE, COND_NEVER,     PC_IDLE};
                PC_PRE_R:  w = '{ACT_REDUCE,     COND_RED_MORE,  PC_PRE_R};
                PC_PRE_W:  w = '{ACT_WB_SQ,      COND_NEVER,     PC_IDLE};
                PC_EZERO:  w = '{ACT_NOP,        COND_EXP_ZERO,  PC_FINISH};
                PC_BIT:    w = '{ACT_NOP,        COND_BIT_CLEAR, PC_SHIFT};
                PC_MUL:    w = '{ACT_MUL_ACC_SQ, COND_NEVER,     PC_IDLE};
                PC_MUL_R:  w = '{ACT_REDUCE,     COND_RED_MORE,  PC_MUL_R};
                PC_MUL_W:  w = '{ACT_WB_ACC,     COND_NEVER,     PC_IDLE};
                PC_SHIFT:  w = '{ACT_SHIFT,      COND_LAST_BIT,  PC_FINISH};
                PC_SQR:    w = '{ACT_MUL_SQ_SQ,  COND_NEVER,     PC_IDLE};
                PC_SQR_R:  w = '{ACT_REDUCE,     COND_RED_MORE,  PC_SQR_R};
                PC_SQR_W:  w = '{ACT_WB_SQ,      COND_ALWAYS,    PC_BIT};
                PC_ZERO:   w = '{ACT_CLR_ACC,    COND_ALWAYS,    PC_FINISH};
                PC_FINISH: w = '{ACT_OUT,        COND_OUT_BUSY,  PC_FINISH};
                default:   w = '{ACT_NOP,        COND_ALWAYS,    PC_IDLE};
            endcase
            return w;
        end
    endfunction

endpackage

// ===== sv/modular_exponentiation.sv =====
// ----------------------------------------------------------------------------
// Modular exponentiation
// Computes base to the power of exponent modulo a configured modulus by
// right-to-left square and multiply, run by a small microcode program.
// ----------------------------------------------------------------------------
// One request is worked on at a time. A zero base or a modulus below two
// gives 0, and a zero exponent gives 1. Every modular multiply forms the
// 31 by 31 bit product, runs the reduction unit, which retires one product
// bit per cycle with a compare and subtract, and writes the result back. A
// finished result waits in an output register, and the next request is
// taken meanwhile. The modulus sits at byte address 0 and resets to
// 1000000007.
`timescale 1ns / 1ps

module modular_exponentiation (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mexp_pkg::APB_AW-1:0]         paddr,
    input  logic [mexp_pkg::APB_DW-1:0]         pwdata,
    output logic [mexp_pkg::APB_DW-1:0]         prdata,
    output logic                                pready,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // Fields from bit 0: base_value (31), exponent (31), zero padding (2).
    input  logic [mexp_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // Fields from bit 0: power_result (30), zero padding (2).
    output logic [mexp_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    import mexp_pkg::*;

    logic [MOD_W-1:0]  r_mod;
    t_pc               r_pc;
    t_pc               n_pc;
    t_ctrl             w_ctrl;
    logic              w_jump;
    logic              w_out_busy;

    logic [OPND_W-1:0] r_sq;
    logic [OPND_W-1:0] r_exp;
    logic [MOD_W-1:0]  r_acc;
    logic [PROD_W-1:0] r_prod;
    logic [MOD_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_out_valid;
    logic [MOD_W-1:0]  r_out_data;

    logic [OPND_W-1:0] w_mul_a;
    logic [OPND_W-1:0] w_mul_b;
    logic [PROD_W-1:0] w_prod;
    logic [MOD_W:0]    w_trial;
    logic [MOD_W:0]    w_mod_ext;
    logic [MOD_W-1:0]  w_rem_next;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod <= MODULUS_RESET;
        end else if (psel && penable && pwrite && pready && paddr == ADDR_MODULUS) begin
            r_mod <= pwdata[MOD_W-1:0];
        end
    end

    always_comb begin
        if (paddr == ADDR_MODULUS) begin
            prdata = APB_DW'(r_mod);
        end else begin
            prdata = '0;
        end
    end

    assign w_ctrl        = ucode_rom(r_pc);
    assign w_out_busy    = r_out_valid && !m_axis_tready;
    assign s_axis_tready = (r_pc == PC_IDLE);

    always_comb begin
        case (w_ctrl.cond)
            COND_NEVER:     w_jump = 1'b0;
            COND_ALWAYS:    w_jump = 1'b1;
            COND_NO_INPUT:  w_jump = !s_axis_tvalid;
            COND_TRIVIAL:   w_jump = (r_sq == '0) || (r_mod < MOD_W'(2));
            COND_RED_MORE:  w_jump = (r_cnt != CNT_W'(1));
            COND_EXP_ZERO:  w_jump = (r_exp == '0);
            COND_BIT_CLEAR: w_jump = !r_exp[0];
            COND_LAST_BIT:  w_jump = (r_exp[OPND_W-1:1] == '0);
            COND_OUT_BUSY:  w_jump = w_out_busy;
            default:        w_jump = 1'b0;
        endcase
        n_pc = w_jump ? w_ctrl.target : r_pc + PC_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    always_comb begin
        case (w_ctrl.act)
            ACT_MUL_SQ_ONE: begin
                w_mul_a = r_sq;
                w_mul_b = OPND_W'(1);
            end
            ACT_MUL_ACC_SQ: begin
                w_mul_a = OPND_W'(r_acc);
                w_mul_b = r_sq;
            end
            default: begin
                w_mul_a = r_sq;
                w_mul_b = r_sq;
            end
        endcase
        w_prod     = PROD_W'(w_mul_a) * PROD_W'(w_mul_b);
        w_trial    = {r_rem, r_prod[PROD_W-1]};
        w_mod_ext  = {1'b0, r_mod};
        if (w_trial >= w_mod_ext) begin
            w_rem_next = MOD_W'(w_trial - w_mod_ext);
        end else begin
            w_rem_next = w_trial[MOD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        case (w_ctrl.act)
            ACT_LOAD: begin
                if (s_axis_tvalid) begin
                    r_sq  <= s_axis_tdata[OPND_W-1:0];
                    r_exp <= s_axis_tdata[2*OPND_W-1:OPND_W];
                    r_acc <= MOD_W'(1);
                end
            end
            ACT_MUL_SQ_ONE, ACT_MUL_ACC_SQ, ACT_MUL_SQ_SQ: begin
                r_prod <= w_prod;
                r_rem  <= '0;
                r_cnt  <= CNT_W'(PROD_W);
            end
            ACT_REDUCE: begin
                r_rem  <= w_rem_next;
                r_prod <= {r_prod[PROD_W-2:0], 1'b0};
                r_cnt  <= r_cnt - CNT_W'(1);
            end
            ACT_WB_SQ: begin
                r_sq <= OPND_W'(r_rem);
            end
            ACT_WB_ACC: begin
                r_acc <= r_rem;
            end
            ACT_SHIFT: begin
                r_exp <= r_exp >> 1;
            end
            ACT_CLR_ACC: begin
                r_acc <= '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctrl.act == ACT_OUT && !w_out_busy) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.act == ACT_OUT && !w_out_busy) begin
            r_out_data <= r_acc;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'(r_out_data);

endmodule

// ===== sv/mexp_chk.sv =====
// ----------------------------------------------------------------------------
// Modular exponentiation checker
// Port-level assertions on the stream and register interfaces.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mexp_chk (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_pready,
    input  logic                                i_s_tvalid,
    input  logic                                i_s_tready,
    input  logic                                i_m_tvalid,
    input  logic                                i_m_tready,
    input  logic [mexp_pkg::OUT_TDATA_W-1:0]    i_m_tdata
);

    import mexp_pkg::*;

    logic w_out_wait;
    logic w_pad_zero;

    assign w_out_wait = i_m_tvalid && !i_m_tready;
    assign w_pad_zero = (i_m_tdata[OUT_TDATA_W-1:MOD_W] == '0);

    // A result that is not taken stays unchanged.
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_out_wait, i_m_tvalid && $stable(i_m_tdata))

    // Only one request is in work, so ready drops after each accepted request.
    `ASSERT_NEXT(a_one_request, i_clk, i_rst_n, i_s_tvalid && i_s_tready, !i_s_tready)

    // An idle block keeps waiting for a request.
    `ASSERT_NEXT(a_idle_waits, i_clk, i_rst_n, i_s_tready && !i_s_tvalid, i_s_tready)

    // A result is always below the modulus range, so the padding bits are zero.
    `ASSERT_IMPLY(a_result_range, i_clk, i_rst_n, i_m_tvalid, w_pad_zero)

    // The register port never inserts wait states.
    `ASSERT_IMPLY(a_apb_ready, i_clk, i_rst_n, 1'b1, i_pready)

endmodule

bind modular_exponentiation mexp_chk u_mexp_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_pready   (pready),
    .i_s_tvalid (s_axis_tvalid),
    .i_s_tready (s_axis_tready),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata)
);
